[rtl/cartridge_bank_mapper_defines.svh]
// Assertion macros used by the checker file.
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define CBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, held off while reset is high.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[rtl/cbm_pkg.sv]
package cbm_pkg;

  localparam int CFG_W = 3;

  // configuration register indexes
  localparam logic CFG_ROM_SIZE = 1'b0;
  localparam logic CFG_RAM_SIZE = 1'b1;

  // access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // result targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // register write regions, bus_address[14:13] below 0x8000
  localparam logic [1:0] REG_RAM_EN = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_UPPER  = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef struct packed {
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } access_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] physical_address;
    logic        is_write;
    logic [7:0]  write_data;
  } result_t;

  typedef struct packed {
    logic       ram_enabled;
    logic [4:0] low_rom_bank;
    logic [1:0] upper_bank_bits;
    logic       banking_mode;
  } bank_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] rom_size_code;
    logic [CFG_W-1:0] ram_size_code;
  } cfg_t;

  // ROM is 32KB << code; code 7 clamps to 2MB
  function automatic logic [20:0] rom_addr_mask(input logic [CFG_W-1:0] code);
    logic [20:0] m;
    case (code)
      3'd0:    m = 21'h007FFF;
      3'd1:    m = 21'h00FFFF;
      3'd2:    m = 21'h01FFFF;
      3'd3:    m = 21'h03FFFF;
      3'd4:    m = 21'h07FFFF;
      3'd5:    m = 21'h0FFFFF;
      default: m = 21'h1FFFFF;
    endcase
    return m;
  endfunction

  function automatic logic [14:0] ram_addr_mask(input logic [CFG_W-1:0] code);
    logic [14:0] m;
    case (code)
      3'd1:    m = 15'h07FF;
      3'd2:    m = 15'h1FFF;
      default: m = 15'h7FFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/cbm_bank_regs.sv]
module cbm_bank_regs import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  access_t     item,
  output bank_state_t bank
);

  logic reg_write;

  assign reg_write = commit && (item.mode == MODE_WRITE) && !item.bus_address[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= '0;
    end else if (reg_write) begin
      case (item.bus_address[14:13])
        REG_RAM_EN: bank.ram_enabled     <= (item.bus_data[3:0] == RAM_EN_KEY);
        REG_LOW:    bank.low_rom_bank    <= item.bus_data[4:0];
        REG_UPPER:  bank.upper_bank_bits <= item.bus_data[1:0];
        REG_MODE:   bank.banking_mode    <= item.bus_data[0];
        default:    bank <= bank;
      endcase
    end
  end

endmodule

[rtl/cbm_translate.sv]
module cbm_translate import cbm_pkg::*; (
  input  access_t     item,
  input  bank_state_t bank,
  input  cfg_t        cfg,
  output result_t     result
);

  logic [6:0]  rom_bank;
  logic [4:0]  low_eff;
  logic [20:0] rom_phys;
  logic [1:0]  ram_bank;
  logic [14:0] ram_phys;
  logic        ram_hit;

  always_comb begin
    // a low bank of zero selects bank one
    low_eff = (bank.low_rom_bank == 5'd0) ? 5'd1 : bank.low_rom_bank;
    if (!item.bus_address[14]) begin
      rom_bank = bank.banking_mode ? {bank.upper_bank_bits, 5'd0} : 7'd0;
    end else begin
      rom_bank = {bank.upper_bank_bits, low_eff};
    end
    rom_phys = {rom_bank, item.bus_address[13:0]} & rom_addr_mask(cfg.rom_size_code);

    ram_bank = bank.banking_mode ? bank.upper_bank_bits : 2'd0;
    ram_phys = {ram_bank, item.bus_address[12:0]} & ram_addr_mask(cfg.ram_size_code);
    ram_hit  = (item.bus_address[15:13] == 3'b101) && bank.ram_enabled &&
               (cfg.ram_size_code != 3'd0);

    result = '0;
    if (!item.bus_address[15]) begin
      if (item.mode == MODE_READ) begin
        result.target           = TGT_ROM;
        result.physical_address = rom_phys;
      end
    end else if (ram_hit) begin
      result.target           = TGT_RAM;
      result.physical_address = {6'd0, ram_phys};
      if (item.mode == MODE_WRITE) begin
        result.is_write   = 1'b1;
        result.write_data = item.bus_data;
      end
    end
  end

endmodule

[rtl/cartridge_bank_mapper.sv]
// Each access passes through an input register, then a result register.
// Throughput: one access per cycle unless out_stall holds a full result register; the
// bank registers update as an item moves to the result register, so the next item
// sees them in the following cycle.
// Reset (rst, synchronous, active high): empties both stages, clears the size codes
// and the four banking registers (RAM disabled, bank zero, simple banking).
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  access_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_data
);

  logic        s1_valid;
  access_t     s1_item;
  logic        out_ready;
  logic        advance;
  cfg_t        cfg;
  bank_state_t bank;
  result_t     result;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_ready;
  assign advance   = s1_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE: cfg.rom_size_code <= cfg_data;
        CFG_RAM_SIZE: cfg.ram_size_code <= cfg_data;
        default:      cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  cbm_bank_regs u_bank_regs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (s1_item),
    .bank   (bank)
  );

  cbm_translate u_translate (
    .item   (s1_item),
    .bank   (bank),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

[rtl/cbm_checker.sv]
`include "cartridge_bank_mapper_defines.svh"

module cbm_checker import cbm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  logic ram_write;
  logic none_hit;
  logic none_clean;

  assign ram_write  = out_valid && out_data.is_write;
  assign none_hit   = out_valid && (out_data.target == TGT_NONE);
  assign none_clean = (out_data.physical_address == 21'd0) && !out_data.is_write &&
                      (out_data.write_data == 8'd0);

  // the input side only backs up when the result register is full and held
  `CBM_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // only RAM accesses write
  `CBM_ASSERT_NOW(a_write_ram, clk, rst, ram_write, out_data.target == TGT_RAM)

  // no target means all other fields are zero
  `CBM_ASSERT_NOW(a_none_zero, clk, rst, none_hit, none_clean)

  // a held result stays put
  `CBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
